/* sv/bfm_pkg.sv */
// Package with shared types and constants of the Bloom filter membership core.
package bfm_pkg;

    localparam int unsigned DEF_MAX_FILTER_BITS = 65536;
    localparam int unsigned DEF_MAX_KEY_BYTES   = 64;
    localparam int unsigned DEF_MAX_HASHES      = 30;

    localparam int unsigned BIT_COUNT_W = 17;
    localparam int unsigned HASH_CNT_W  = 5;
    localparam int unsigned CFG_DATA_W  = 17;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

    localparam logic [0:0] REG_BIT_COUNT = 1'b0;
    localparam logic [0:0] REG_HASHES    = 1'b1;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Operations of the shared 64-bit hash unit.
    typedef enum logic [2:0] {
        HOP_LOAD,
        HOP_BYTE,
        HOP_MULG,
        HOP_SH27,
        HOP_MUL1,
        HOP_SH31,
        HOP_MUL2,
        HOP_SH32
    } hop_t;

    typedef struct packed {
        logic start;
        hop_t op;
    } hash_ctl_t;

endpackage

/* sv/bloom_filter_membership_core.sv */
// Top level of the Bloom filter membership core with its sequencer and stores.
// Key-byte words are taken while idle; a clear word sweeps the bit store one
// entry a cycle, as does the clearing pass after reset, and no word is
// accepted during the sweep. A finish word runs, per hash, one load, per key
// byte one buffer read, one xor, a multiply and one shift, then the finalizer
// (two multiplies, two shifts), then a modulo and one bit-store access. The
// hashing runs through one shared hash unit, so the hashes are done one after
// another; a query stops after the first clear bit and an overflowed key skips
// hashing.
module bloom_filter_membership_core
    import bfm_pkg::*;
#(
    parameter int unsigned MAX_FILTER_BITS = DEF_MAX_FILTER_BITS,
    parameter int unsigned MAX_KEY_BYTES   = DEF_MAX_KEY_BYTES,
    parameter int unsigned MAX_HASHES      = DEF_MAX_HASHES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [7:0]            key_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  maybe_present,
    output logic [31:0]           items_added,
    output logic                  status
);
    localparam int unsigned ADDR_W = (MAX_FILTER_BITS > 1) ? $clog2(MAX_FILTER_BITS) : 1;
    localparam int unsigned M_W    = $clog2(MAX_FILTER_BITS + 1);
    localparam int unsigned KA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int unsigned LEN_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int unsigned S_W    = $clog2(MAX_HASHES + 1);

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_LOAD, ST_RDB, ST_BYTE, ST_MULG, ST_SH27,
        ST_MUL1, ST_SH31, ST_MUL2, ST_SH32, ST_MOD, ST_BIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [BIT_COUNT_W-1:0] bitcnt_reg;
    logic [HASH_CNT_W-1:0]  hcnt_reg;
    logic [7:0]             kbuf [MAX_KEY_BYTES];
    logic [7:0]             kbyte_reg;
    logic                   fbits [MAX_FILTER_BITS];
    logic                   frd_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   ovf_reg;
    logic [31:0]            cnt_reg;
    logic [LEN_W-1:0]       idx_reg;
    logic [S_W-1:0]         seed_reg;
    logic [ADDR_W:0]        clr_reg;
    logic                   isadd_reg, pres_reg, stat_reg;
    logic [M_W-1:0]         pos_reg;

    logic [M_W-1:0] m_used;
    logic [S_W-1:0] k_used;
    hash_ctl_t      hctl;
    logic [63:0]    hash;
    logic           mul_done, mod_start, mod_done;
    logic [M_W-1:0] rem;
    logic           acc_in, acc_out;
    logic           last_seed;

    always_comb
    begin
        if ({{(32-BIT_COUNT_W){1'b0}}, bitcnt_reg} < 32'd64)
            m_used = M_W'(64);
        else if ({{(32-BIT_COUNT_W){1'b0}}, bitcnt_reg} > 32'(MAX_FILTER_BITS))
            m_used = M_W'(MAX_FILTER_BITS);
        else
            m_used = M_W'(bitcnt_reg);
        if (hcnt_reg == '0)
            k_used = S_W'(1);
        else if ({27'd0, hcnt_reg} > 32'(MAX_HASHES))
            k_used = S_W'(MAX_HASHES);
        else
            k_used = S_W'(hcnt_reg);
    end

    assign acc_in    = in_valid && in_ready;
    assign acc_out   = out_valid && out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign last_seed = (seed_reg + S_W'(1)) == k_used;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (clr_reg == (ADDR_W+1)'(MAX_FILTER_BITS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (acc_in)
                begin
                    if (cmd == CMD_CLEAR)
                        state_next = ST_INIT;
                    else if (cmd != CMD_BYTE)
                        state_next = ovf_reg ? ST_OUT : ST_LOAD;
                end
            ST_LOAD: state_next = (idx_reg == len_reg) ? ST_MUL1 : ST_RDB;
            ST_RDB:  state_next = ST_BYTE;
            ST_BYTE: state_next = ST_MULG;
            ST_MULG: if (mul_done) state_next = ST_SH27;
            ST_SH27: state_next = (idx_reg == len_reg) ? ST_MUL1 : ST_RDB;
            ST_MUL1: if (mul_done) state_next = ST_SH31;
            ST_SH31: state_next = ST_MUL2;
            ST_MUL2: if (mul_done) state_next = ST_SH32;
            ST_SH32: state_next = ST_MOD;
            ST_MOD:  if (mod_done) state_next = ST_BIT;
            ST_BIT:
                if (last_seed || (!isadd_reg && !frd_reg))
                    state_next = ST_OUT;
                else
                    state_next = ST_LOAD;
            ST_OUT:  if (acc_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        hctl.start = 1'b0;
        hctl.op    = HOP_LOAD;
        mod_start  = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin hctl.start = 1'b1; hctl.op = HOP_LOAD; end
            ST_BYTE: begin hctl.start = 1'b1; hctl.op = HOP_BYTE; end
            ST_MULG: begin hctl.start = 1'b1; hctl.op = HOP_MULG; end
            ST_SH27: begin hctl.start = 1'b1; hctl.op = HOP_SH27; end
            ST_MUL1: begin hctl.start = 1'b1; hctl.op = HOP_MUL1; end
            ST_SH31: begin hctl.start = 1'b1; hctl.op = HOP_SH31; end
            ST_MUL2: begin hctl.start = 1'b1; hctl.op = HOP_MUL2; end
            ST_SH32:
            begin
                hctl.start = 1'b1;
                hctl.op    = HOP_SH32;
                mod_start  = 1'b1;
            end
            default: ;
        endcase
    end

    bfm_hash_unit #(.LEN_W(LEN_W)) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hctl),
        .seed     ({{(64-S_W){1'b0}}, seed_reg}),
        .len      (len_reg),
        .key_byte (kbyte_reg),
        .hash     (hash),
        .mul_done (mul_done)
    );

    // The shift result lands in the hash register at the edge that starts the
    // divide, so the start is registered and the divide loads the finished hash in the next cycle.
    logic mod_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_go_reg <= 1'b0;
        else
            mod_go_reg <= mod_start;
    end

    bfm_mod_unit #(.M_W(M_W)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_go_reg),
        .dividend  (hash),
        .divisor   (m_used),
        .done      (mod_done),
        .remainder (rem)
    );

    // Key buffer and bit store.
    always_ff @(posedge clk)
    begin
        if (acc_in && cmd == CMD_BYTE && len_reg < LEN_W'(MAX_KEY_BYTES))
            kbuf[len_reg[KA_W-1:0]] <= key_byte;
        kbyte_reg <= kbuf[idx_reg[KA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
            fbits[clr_reg[ADDR_W-1:0]] <= 1'b0;
        else if (state_reg == ST_BIT && isadd_reg)
            fbits[pos_reg[ADDR_W-1:0]] <= 1'b1;
        frd_reg <= fbits[rem[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            bitcnt_reg <= BIT_COUNT_W'(65536);
            hcnt_reg   <= HASH_CNT_W'(7);
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            seed_reg   <= '0;
            clr_reg    <= '0;
            isadd_reg  <= 1'b0;
            pres_reg   <= 1'b0;
            stat_reg   <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIT_COUNT: bitcnt_reg <= cfg_data[BIT_COUNT_W-1:0];
                    REG_HASHES:    hcnt_reg <= cfg_data[HASH_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_INIT)
                clr_reg <= clr_reg + (ADDR_W+1)'(1);
            if (state_reg == ST_IDLE && acc_in)
            begin
                clr_reg <= '0;
                unique case (cmd_t'(cmd))
                    CMD_BYTE:
                        if (len_reg < LEN_W'(MAX_KEY_BYTES))
                            len_reg <= len_reg + LEN_W'(1);
                        else
                            ovf_reg <= 1'b1;
                    CMD_CLEAR: cnt_reg <= '0;
                    default:
                    begin
                        isadd_reg <= (cmd == CMD_ADD);
                        pres_reg  <= 1'b0;
                        stat_reg  <= ovf_reg;
                        seed_reg  <= '0;
                        idx_reg   <= '0;
                    end
                endcase
            end
            if (state_reg == ST_RDB)
                idx_reg <= idx_reg + LEN_W'(1);
            if (state_reg == ST_MOD && mod_done)
                pos_reg <= rem;
            if (state_reg == ST_BIT)
            begin
                idx_reg  <= '0;
                seed_reg <= seed_reg + S_W'(1);
                if (!isadd_reg)
                    pres_reg <= frd_reg;
                if (state_next == ST_OUT && isadd_reg && cnt_reg != 32'hFFFF_FFFF)
                    cnt_reg <= cnt_reg + 32'd1;
            end
            if (state_reg == ST_OUT && acc_out)
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
        end
    end

    assign maybe_present = pres_reg && !isadd_reg && !stat_reg;
    assign items_added   = cnt_reg;
    assign status        = stat_reg;

`ifndef SYNTHESIS
    a_ready_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and result valid together");
    a_status_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> !maybe_present) else $error("hit on overflowed key");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_KEY_BYTES)) else $error("key length past buffer");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(items_added)) else $error("count moved");
`endif
endmodule

/* sv/bfm_hash_unit.sv */
// Shared 64-bit hash datapath: xor, multiply in 32-bit slices, xorshift.
module bfm_hash_unit
    import bfm_pkg::*;
#(
    parameter int unsigned LEN_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hash_ctl_t        ctl,
    input  logic [63:0]      seed,
    input  logic [LEN_W-1:0] len,
    input  logic [7:0]       key_byte,
    output logic [63:0]      hash,
    output logic             mul_done
);
    // Multiply modulo 2^64 as three 32x32 partial products, accumulated in turn.
    logic [63:0] h_reg, h_next;
    logic [1:0]  ph_reg, ph_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mulc;
    logic [63:0] lenmul;
    logic [31:0] pa, pb;
    logic [63:0] prod;

    assign lenmul = {{(64-LEN_W){1'b0}}, len} * GOLDEN;

    always_comb
    begin
        unique case (ctl.op)
            HOP_MUL1: mulc = MIX1;
            HOP_MUL2: mulc = MIX2;
            default:  mulc = GOLDEN;
        endcase
    end

    always_comb
    begin
        case (ph_reg)
            2'd0:    begin pa = h_reg[31:0];  pb = mulc[31:0];  end
            2'd1:    begin pa = h_reg[31:0];  pb = mulc[63:32]; end
            default: begin pa = h_reg[63:32]; pb = mulc[31:0];  end
        endcase
        prod = {32'd0, pa} * {32'd0, pb};
    end

    always_comb
    begin
        h_next   = h_reg;
        ph_next  = 2'd0;
        acc_next = acc_reg;
        mul_done = 1'b0;
        if (ctl.start)
        begin
            unique case (ctl.op)
                HOP_LOAD: h_next = seed ^ lenmul;
                HOP_BYTE: h_next = h_reg ^ {56'd0, key_byte};
                HOP_SH27: h_next = h_reg ^ (h_reg >> 27);
                HOP_SH31: h_next = h_reg ^ (h_reg >> 31);
                HOP_SH32: h_next = h_reg ^ (h_reg >> 32);
                default:
                begin
                    case (ph_reg)
                        2'd0:
                        begin
                            acc_next = prod;
                            ph_next  = 2'd1;
                        end
                        2'd1:
                        begin
                            acc_next = acc_reg + {prod[31:0], 32'd0};
                            ph_next  = 2'd2;
                        end
                        default:
                        begin
                            h_next   = acc_reg + {prod[31:0], 32'd0};
                            mul_done = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ph_reg <= 2'd0;
        else
            ph_reg <= ph_next;
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        acc_reg <= acc_next;
    end

    assign hash = h_reg;
endmodule

/* sv/bfm_mod_unit.sv */
// Restoring modulo unit: reduces a 64-bit hash by the bit count, one bit a cycle.
module bfm_mod_unit
    import bfm_pkg::*;
#(
    parameter int unsigned M_W = 17
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [63:0]    dividend,
    input  logic [M_W-1:0] divisor,
    output logic           done,
    output logic [M_W-1:0] remainder
);
    logic [63:0]  q_reg, q_next;
    logic [M_W:0] r_reg, r_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic [M_W:0] sh;

    assign sh = {r_reg[M_W-1:0], q_reg[63]};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[62:0], 1'b0};
            if (sh >= {1'b0, divisor})
                r_next = sh - {1'b0, divisor};
            else
                r_next = sh;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign remainder = r_next[M_W-1:0];
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Bloom filter membership core.
module testbench;
    import bfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FILTER_SIZE = DEF_MAX_FILTER_BITS;
    localparam int unsigned KEY_CAP     = DEF_MAX_KEY_BYTES;
    localparam int unsigned HASH_CAP    = DEF_MAX_HASHES;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            cmd;
    logic [7:0]            key_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  maybe_present;
    logic [31:0]           items_added;
    logic                  status;

    bloom_filter_membership_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key_byte     (key_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .maybe_present(maybe_present),
        .items_added  (items_added),
        .status       (status)
    );

    typedef struct packed {
        logic        present;
        logic [31:0] count;
        logic        status;
    } answer_t;

    answer_t pending_answers[$];
    int      error_count;

    // Shadow copy of the block state.
    logic [BIT_COUNT_W-1:0] bit_count_reg;
    logic [HASH_CNT_W-1:0]  hash_count_reg;
    bit                     shadow_bits[FILTER_SIZE];
    logic [7:0]             shadow_key[KEY_CAP];
    int unsigned            shadow_len;
    bit                     shadow_overflow;
    logic [31:0]            shadow_added;

    // Stimulus controls shared with the result side.
    bit quiet;
    int hold_off;

    logic [7:0] key_work[$];
    logic [7:0] saved_keys[8][16];
    int         saved_lens[8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [63:0] key_digest(input int unsigned seed);
        logic [63:0] h;
        h = 64'(seed) ^ (64'(shadow_len) * GOLDEN);
        for (int i = 0; i < shadow_len; i++)
        begin
            h = h ^ 64'(shadow_key[i]);
            h = h * GOLDEN;
            h = h ^ (h >> 27);
        end
        h = h * MIX1;
        h = h ^ (h >> 31);
        h = h * MIX2;
        h = h ^ (h >> 32);
        return h;
    endfunction

    task automatic predict_word(input logic [1:0] c, input logic [7:0] b);
        logic [63:0] m;
        logic [63:0] pos;
        int unsigned k;
        answer_t     a;
        if (c == CMD_BYTE)
        begin
            if (shadow_len < KEY_CAP)
            begin
                shadow_key[shadow_len] = b;
                shadow_len++;
            end
            else
                shadow_overflow = 1'b1;
            return;
        end
        if (c == CMD_CLEAR)
        begin
            for (int i = 0; i < FILTER_SIZE; i++)
                shadow_bits[i] = 1'b0;
            shadow_added = '0;
            return;
        end
        m = 64'(bit_count_reg);
        if (m < 64)
            m = 64;
        if (m > FILTER_SIZE)
            m = FILTER_SIZE;
        k = hash_count_reg;
        if (k < 1)
            k = 1;
        if (k > HASH_CAP)
            k = HASH_CAP;
        a = '0;
        if (shadow_overflow)
            a.status = 1'b1;
        else if (c == CMD_ADD)
        begin
            for (int s = 0; s < k; s++)
            begin
                pos = key_digest(s) % m;
                shadow_bits[pos] = 1'b1;
            end
            if (shadow_added != 32'hFFFF_FFFF)
                shadow_added++;
        end
        else
        begin
            a.present = 1'b1;
            for (int s = 0; s < k; s++)
            begin
                pos = key_digest(s) % m;
                if (!shadow_bits[pos])
                    a.present = 1'b0;
            end
        end
        a.count = shadow_added;
        shadow_len = 0;
        shadow_overflow = 1'b0;
        pending_answers.push_back(a);
    endtask

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic [1:0] c, input logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < 12) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(c, b);
    endtask

    task automatic send_key_work();
        foreach (key_work[i])
            send_word(CMD_BYTE, key_work[i]);
    endtask

    task automatic make_key(input int len, input int fill);
        key_work.delete();
        for (int i = 0; i < len; i++)
            key_work.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    task automatic finish_key(input logic [1:0] c);
        send_word(c, 8'($urandom));
    endtask

    // The phase must end with a finish word, so an empty queue means idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BIT_COUNT)
            bit_count_reg = val[BIT_COUNT_W-1:0];
        else
            hash_count_reg = val[HASH_CNT_W-1:0];
    endtask

    task automatic set_config(input int bits, input int hashes);
        wait_idle();
        write_reg(REG_BIT_COUNT, CFG_DATA_W'(bits));
        write_reg(REG_HASHES, CFG_DATA_W'(hashes));
    endtask

    // Result side: checks every taken word and stalls at random unless quiet, or while hold_off counts down.
    initial
    begin
        answer_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected result word");
                    error_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (maybe_present !== want.present)
                    begin
                        $error("maybe_present: expected %0d, actual %0d",
                               want.present, maybe_present);
                        error_count++;
                    end
                    if (items_added !== want.count)
                    begin
                        $error("items_added: expected %0d, actual %0d",
                               want.count, items_added);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        error_count++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 12);
        end
    end

    task automatic test_basic_keys();
        finish_key(CMD_QUERY);
        finish_key(CMD_ADD);
        finish_key(CMD_QUERY);
        make_key(3, 0);
        send_key_work();
        finish_key(CMD_QUERY);
        send_key_work();
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
        make_key(4, 8'hFF);
        send_key_work();
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
        make_key(2, 8'h5A);
        send_key_work();
        finish_key(CMD_QUERY);
    endtask

    task automatic test_key_overflow();
        make_key(KEY_CAP, -1);
        send_key_work();
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
        make_key(KEY_CAP + 3, -1);
        send_key_work();
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
        // The key after an ignored one starts clean.
        make_key(1, 8'h80);
        send_key_work();
        finish_key(CMD_ADD);
    endtask

    task automatic test_clear();
        make_key(2, 8'h11);
        send_key_work();
        finish_key(CMD_ADD);
        // A clear between bytes leaves the pending key in place.
        send_word(CMD_BYTE, 8'h22);
        send_word(CMD_CLEAR, 8'h00);
        send_word(CMD_BYTE, 8'h33);
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
    endtask

    task automatic test_config_extremes();
        set_config(0, 0);
        test_basic_keys();
        set_config(64, 30);
        for (int i = 0; i < 6; i++)
        begin
            make_key($urandom_range(0, 3), -1);
            send_key_work();
            finish_key(i % 2 ? CMD_QUERY : CMD_ADD);
        end
        set_config(18'h1FFFF, 31);
        make_key(KEY_CAP, -1);
        send_key_work();
        finish_key(CMD_ADD);
        send_key_work();
        finish_key(CMD_QUERY);
        set_config(65536, 1);
        test_basic_keys();
    endtask

    task automatic test_backpressure();
        hold_off = 3000;
        for (int i = 0; i < 40; i++)
        begin
            make_key($urandom_range(0, 2), -1);
            send_key_work();
            finish_key(i % 3 ? CMD_QUERY : CMD_ADD);
        end
    endtask

    task automatic test_random();
        int words;
        int slot;
        int r;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                set_config($urandom_range(0, 18'h1FFFF), $urandom_range(0, 31));
            else
                set_config($urandom_range(64, 65536), $urandom_range(1, 6));
            quiet = (phase == 2);
            words = 0;
            while (words < 160)
            begin
                r = $urandom_range(0, 99);
                slot = $urandom_range(0, 7);
                if (r < 2 && phase % 3 == 1)
                begin
                    send_word(CMD_CLEAR, 8'($urandom));
                    words++;
                end
                else if (r < 5)
                begin
                    make_key($urandom_range(KEY_CAP + 1, KEY_CAP + 4), -1);
                    send_key_work();
                    finish_key(2'($urandom_range(1, 2)));
                    words += key_work.size() + 1;
                end
                else if (r < 45)
                begin
                    key_work.delete();
                    for (int i = 0; i < saved_lens[slot]; i++)
                        key_work.push_back(saved_keys[slot][i]);
                    send_key_work();
                    finish_key(CMD_QUERY);
                    words += key_work.size() + 1;
                end
                else
                begin
                    make_key($urandom_range(0, 8), -1);
                    send_key_work();
                    if (r < 75)
                    begin
                        saved_lens[slot] = key_work.size();
                        foreach (key_work[i])
                            saved_keys[slot][i] = key_work[i];
                        finish_key(CMD_ADD);
                    end
                    else
                        finish_key(CMD_QUERY);
                    words += key_work.size() + 1;
                end
            end
            finish_key(CMD_QUERY);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        cmd       = CMD_BYTE;
        key_byte  = '0;
        quiet     = 1'b0;
        hold_off  = 0;
        error_count = 0;
        bit_count_reg  = 17'd65536;
        hash_count_reg = 5'd7;
        shadow_len      = 0;
        shadow_overflow = 1'b0;
        shadow_added    = '0;
        for (int i = 0; i < FILTER_SIZE; i++)
            shadow_bits[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            saved_lens[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_keys();
        test_key_overflow();
        test_clear();
        test_config_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/bfm_pkg.sv
sv/bfm_hash_unit.sv
sv/bfm_mod_unit.sv
sv/bloom_filter_membership_core.sv
tb/testbench.sv
